FILE: rtl/core/ddlr_pkg.sv
// Shared types and constants of the dash-dot line rasterizer.
package ddlr_pkg;

    // Width of the two pattern registers and of the scaled lengths.
    localparam int CFG_BITS = 6;

    // Register indexes on the configuration port (byte address is four times this).
    localparam logic [0:0] REG_DASH_IDX = 1'b0;
    localparam logic [0:0] REG_GAP_IDX  = 1'b1;

    // Register values after reset.
    localparam logic [CFG_BITS-1:0] DASH_RESET = 6'd4;
    localparam logic [CFG_BITS-1:0] GAP_RESET  = 6'd2;

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_PREP = 13'b0000000000010,
        S_SQ0  = 13'b0000000000100,
        S_SQ1  = 13'b0000000001000,
        S_ROOT = 13'b0000000010000,
        S_DMUL = 13'b0000000100000,
        S_DDIV = 13'b0000001000000,
        S_GMUL = 13'b0000010000000,
        S_GDIV = 13'b0000100000000,
        S_INIT = 13'b0001000000000,
        S_HEAD = 13'b0010000000000,
        S_DRAW = 13'b0100000000000,
        S_TAIL = 13'b1000000000000
    } t_state;

endpackage

FILE: rtl/core/dash_dot_line_rasterizer_unit.sv
// Dash-dot line rasterizer: takes one line command and streams out its plotted pixels.
//
// One command word is taken while the block is idle; o_s_tready stays low until the
// final pixel has been loaded into the output register. A line within one row or
// column is walked from its smaller coordinate and closes on its larger end. Any other
// line first runs a setup on one shared multiplier with a compare against a target
// register: decode, two squares, a bit-by-bit floor square root of COORD_BITS+1 steps,
// then a product and a bit-by-bit quotient of six steps for each of the scaled dash
// and gap, and the pattern load. The walk then takes the start pixel, makes one
// major-axis step per cycle while the output word can be loaded (major - 1 steps),
// leaves the walk and takes the end pixel. A pixel waits whenever the output word
// is not taken.
module dash_dot_line_rasterizer_unit
    import ddlr_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int COLOR_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Command words.
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // tdata: start_row, start_col, end_row, end_col, pen_color (lowest bit up).
    input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: xor_mode.
    input  logic                         i_s_tuser,
    // Pixel words.
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // tdata: pixel_row, pixel_col, pixel_color (lowest bit up).
    output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] o_m_tdata,
    // tuser: pixel_xor.
    output logic                         o_m_tuser,
    output logic                         o_m_tlast,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CB     = COORD_BITS;
    localparam int RW     = CB + 1;
    localparam int MW     = (RW > CFG_BITS) ? RW : CFG_BITS;
    localparam int PW     = 2 * MW;
    localparam int BCW    = $clog2(MW);
    localparam int OUT_TW = ((2*CB + COLOR_BITS + 7) / 8) * 8;

    // Configuration registers.
    logic [CFG_BITS-1:0] r_dash_len, r_gap_len;
    logic                cfg_wr;
    logic [0:0]          cfg_idx;

    // Sequencer and command registers.
    t_state              r_state, n_state;
    logic [CB-1:0]       r_r1, r_c1, r_r2, r_c2;
    logic [COLOR_BITS-1:0] r_color;
    logic                r_xor;

    // Walk registers.
    logic [CB-1:0]       r_u, n_u, r_v, n_v;
    logic [CB-1:0]       r_m, n_m, r_mn, n_mn;
    logic [CB-1:0]       r_steps, n_steps;
    logic [CB:0]         r_acc, n_acc;
    logic                r_udec, n_udec, r_vdec, n_vdec;
    logic                r_rowmajor, n_rowmajor, r_diag, n_diag;

    // Pattern registers.
    logic [CFG_BITS-1:0] r_sd, n_sd, r_sg, n_sg, r_dc, n_dc;
    logic [CFG_BITS:0]   r_gc, n_gc;

    // Shared multiply and compare unit state.
    logic [PW-1:0]       r_target, n_target;
    logic [RW-1:0]       r_root, n_root;
    logic [CFG_BITS-1:0] r_quo, n_quo;
    logic [BCW-1:0]      r_bit, n_bit;

    // Output register.
    logic                r_ovalid, n_ovalid;
    logic [CB-1:0]       r_o_row, n_o_row, r_o_col, n_o_col;
    logic [COLOR_BITS-1:0] r_o_color, n_o_color;
    logic                r_o_xor, n_o_xor, r_o_last, n_o_last;

    logic                s_accept, out_free;

    // Configuration write and read.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_DASH_IDX: prdata = 32'(r_dash_len);
            REG_GAP_IDX:  prdata = 32'(r_gap_len);
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash_len <= DASH_RESET;
            r_gap_len  <= GAP_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx == REG_DASH_IDX) begin
                r_dash_len <= pwdata[CFG_BITS-1:0];
            end else begin
                r_gap_len <= pwdata[CFG_BITS-1:0];
            end
        end
    end

    // Handshakes and output ports.
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign out_free   = ~r_ovalid | i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_TW'({r_o_color, r_o_col, r_o_row});
    assign o_m_tuser  = r_o_xor;
    assign o_m_tlast  = r_o_last;

    // Shared unit: one multiplier and one compare against the target register.
    logic [MW-1:0]       mul_a, mul_b;
    logic [PW-1:0]       mul_p;
    logic                mul_le;
    logic [MW-1:0]       bit_mask;
    logic [RW-1:0]       trial_root;
    logic [CFG_BITS-1:0] trial_q, q_new;

    assign bit_mask   = MW'(1) << r_bit;
    assign trial_root = r_root | bit_mask[RW-1:0];
    assign trial_q    = r_quo | bit_mask[CFG_BITS-1:0];
    assign mul_p      = mul_a * mul_b;
    assign mul_le     = (mul_p <= r_target);
    assign q_new      = mul_le ? trial_q : r_quo;

    always_comb begin
        case (r_state)
            S_SQ0:   begin mul_a = MW'(r_m);        mul_b = MW'(r_m);      end
            S_SQ1:   begin mul_a = MW'(r_mn);       mul_b = MW'(r_mn);     end
            S_ROOT:  begin mul_a = MW'(trial_root); mul_b = MW'(trial_root); end
            S_DMUL:  begin mul_a = MW'(r_dash_len); mul_b = MW'(r_m);      end
            S_GMUL:  begin mul_a = MW'(r_gap_len);  mul_b = MW'(r_m);      end
            S_DDIV,
            S_GDIV:  begin mul_a = MW'(trial_q);    mul_b = MW'(r_root);   end
            default: begin mul_a = '0;              mul_b = '0;            end
        endcase
    end

    // Command decode: differences, magnitudes and directions.
    logic [CB:0]   d_r, d_c, nd_r, nd_c;
    logic [CB-1:0] ad_r, ad_c;
    logic          neg_r, neg_c, same_row, axis;

    always_comb begin
        d_r      = {1'b0, r_r2} - {1'b0, r_r1};
        d_c      = {1'b0, r_c2} - {1'b0, r_c1};
        nd_r     = -d_r;
        nd_c     = -d_c;
        neg_r    = d_r[CB];
        neg_c    = d_c[CB];
        ad_r     = neg_r ? nd_r[CB-1:0] : d_r[CB-1:0];
        ad_c     = neg_c ? nd_c[CB-1:0] : d_c[CB-1:0];
        same_row = (ad_r == '0);
        axis     = same_row || (ad_c == '0);
    end

    // Dash-dot pattern step for one pixel.
    logic                pat_hit;
    logic [CFG_BITS-1:0] pat_dc;
    logic [CFG_BITS:0]   pat_gc, gc_dec, gap_span;

    assign gap_span = {r_sg, 1'b1};

    always_comb begin
        pat_dc  = r_dc;
        pat_gc  = r_gc;
        pat_hit = 1'b1;
        gc_dec  = (r_gc != '0) ? r_gc - 1'b1 : r_gc;
        if (r_sd != '0) begin
            if (r_dc != '0) begin
                pat_dc = r_dc - 1'b1;
                if (r_dc == CFG_BITS'(1)) begin
                    pat_gc = gap_span;
                end
            end else begin
                pat_hit = (r_gc == ({1'b0, r_sg} + 1'b1));
                pat_gc  = gc_dec;
                if (gc_dec == '0) begin
                    pat_dc = r_sd;
                end
            end
        end
    end

    // DDA step along the major axis.
    logic [CB:0]   dda_sum, dda_red;
    logic          dda_carry;
    logic [CB-1:0] dda_u, dda_v;

    always_comb begin
        dda_sum   = r_acc + {1'b0, r_mn};
        dda_carry = (dda_sum >= {1'b0, r_m});
        dda_red   = dda_carry ? dda_sum - {1'b0, r_m} : dda_sum;
        dda_u     = r_udec ? r_u - 1'b1 : r_u + 1'b1;
        dda_v     = r_v;
        if (dda_carry) begin
            dda_v = r_vdec ? r_v - 1'b1 : r_v + 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_u        = r_u;
        n_v        = r_v;
        n_m        = r_m;
        n_mn       = r_mn;
        n_steps    = r_steps;
        n_acc      = r_acc;
        n_udec     = r_udec;
        n_vdec     = r_vdec;
        n_rowmajor = r_rowmajor;
        n_diag     = r_diag;
        n_sd       = r_sd;
        n_sg       = r_sg;
        n_dc       = r_dc;
        n_gc       = r_gc;
        n_target   = r_target;
        n_root     = r_root;
        n_quo      = r_quo;
        n_bit      = r_bit;
        n_ovalid   = r_ovalid & ~i_m_tready;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_color  = r_o_color;
        n_o_xor    = r_o_xor;
        n_o_last   = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_PREP;
                end
            end

            // Pick the walk: axis-aligned from the smaller coordinate, else a DDA.
            S_PREP: begin
                n_acc = '0;
                if (axis) begin
                    n_diag     = 1'b0;
                    n_udec     = 1'b0;
                    n_sd       = r_dash_len;
                    n_sg       = r_gap_len;
                    n_dc       = r_dash_len;
                    n_gc       = '0;
                    n_rowmajor = ~same_row;
                    if (same_row) begin
                        n_u     = (r_c1 < r_c2) ? r_c1 : r_c2;
                        n_v     = r_r2;
                        n_steps = ad_c;
                    end else begin
                        n_u     = (r_r1 < r_r2) ? r_r1 : r_r2;
                        n_v     = r_c2;
                        n_steps = ad_r;
                    end
                    n_state = S_DRAW;
                end else begin
                    n_diag = 1'b1;
                    if (ad_r < ad_c) begin
                        n_rowmajor = 1'b0;
                        n_m        = ad_c;
                        n_mn       = ad_r;
                        n_udec     = neg_c;
                        n_vdec     = neg_r;
                        n_u        = r_c1;
                        n_v        = r_r1;
                        n_steps    = ad_c - 1'b1;
                    end else begin
                        n_rowmajor = 1'b1;
                        n_m        = ad_r;
                        n_mn       = ad_c;
                        n_udec     = neg_r;
                        n_vdec     = neg_c;
                        n_u        = r_r1;
                        n_v        = r_c1;
                        n_steps    = ad_r - 1'b1;
                    end
                    n_state = S_SQ0;
                end
            end

            // Sum of squares of the two axis lengths.
            S_SQ0: begin
                n_target = mul_p;
                n_state  = S_SQ1;
            end

            S_SQ1: begin
                n_target = r_target + mul_p;
                n_root   = '0;
                n_bit    = BCW'(RW - 1);
                n_state  = S_ROOT;
            end

            // Floor square root, one result bit a cycle.
            S_ROOT: begin
                if (mul_le) begin
                    n_root = trial_root;
                end
                if (r_bit == '0) begin
                    n_state = S_DMUL;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end

            // Scaled dash: dash_length * major / root.
            S_DMUL: begin
                n_target = mul_p;
                n_quo    = '0;
                n_bit    = BCW'(CFG_BITS - 1);
                n_state  = S_DDIV;
            end

            S_DDIV: begin
                n_quo = q_new;
                if (r_bit == '0) begin
                    n_sd    = q_new;
                    n_state = S_GMUL;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end

            // Scaled gap: gap_length * major / root.
            S_GMUL: begin
                n_target = mul_p;
                n_quo    = '0;
                n_bit    = BCW'(CFG_BITS - 1);
                n_state  = S_GDIV;
            end

            S_GDIV: begin
                n_quo = q_new;
                if (r_bit == '0) begin
                    n_sg    = q_new;
                    n_state = S_INIT;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end

            // The start pixel uses up one dash pixel.
            S_INIT: begin
                n_dc = (r_sd != '0) ? r_sd - 1'b1 : r_sd;
                n_gc = (r_sd == CFG_BITS'(1)) ? gap_span : '0;
                n_state = S_HEAD;
            end

            S_HEAD: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_o_row   = r_r1;
                    n_o_col   = r_c1;
                    n_o_color = r_color;
                    n_o_xor   = r_xor;
                    n_o_last  = 1'b0;
                    n_state   = S_DRAW;
                end
            end

            // One pixel step a cycle while the output word can be loaded.
            S_DRAW: begin
                if (r_steps == '0) begin
                    n_state = S_TAIL;
                end else if (out_free) begin
                    n_steps = r_steps - 1'b1;
                    n_dc    = pat_dc;
                    n_gc    = pat_gc;
                    if (r_diag) begin
                        n_u   = dda_u;
                        n_v   = dda_v;
                        n_acc = dda_red;
                    end else begin
                        n_u = r_u + 1'b1;
                    end
                    if (pat_hit) begin
                        n_ovalid  = 1'b1;
                        n_o_color = r_color;
                        n_o_xor   = r_xor;
                        n_o_last  = 1'b0;
                        if (r_diag) begin
                            n_o_row = r_rowmajor ? dda_u : dda_v;
                            n_o_col = r_rowmajor ? dda_v : dda_u;
                        end else begin
                            n_o_row = r_rowmajor ? r_u : r_v;
                            n_o_col = r_rowmajor ? r_v : r_u;
                        end
                    end
                end
            end

            // The closing pixel: the second endpoint of a DDA line, or the larger
            // end of a row or column line, where the walk has stopped.
            S_TAIL: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_o_color = r_color;
                    n_o_xor   = r_xor;
                    n_o_last  = 1'b1;
                    if (r_diag) begin
                        n_o_row = r_r2;
                        n_o_col = r_c2;
                    end else begin
                        n_o_row = r_rowmajor ? r_u : r_v;
                        n_o_col = r_rowmajor ? r_v : r_u;
                    end
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_r1    <= i_s_tdata[CB-1:0];
            r_c1    <= i_s_tdata[2*CB-1:CB];
            r_r2    <= i_s_tdata[3*CB-1:2*CB];
            r_c2    <= i_s_tdata[4*CB-1:3*CB];
            r_color <= i_s_tdata[4*CB+COLOR_BITS-1:4*CB];
            r_xor   <= i_s_tuser;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_v        <= n_v;
        r_m        <= n_m;
        r_mn       <= n_mn;
        r_steps    <= n_steps;
        r_acc      <= n_acc;
        r_udec     <= n_udec;
        r_vdec     <= n_vdec;
        r_rowmajor <= n_rowmajor;
        r_diag     <= n_diag;
        r_sd       <= n_sd;
        r_sg       <= n_sg;
        r_dc       <= n_dc;
        r_gc       <= n_gc;
        r_target   <= n_target;
        r_root     <= n_root;
        r_quo      <= n_quo;
        r_bit      <= n_bit;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_color  <= n_o_color;
        r_o_xor    <= n_o_xor;
        r_o_last   <= n_o_last;
    end

`ifndef ASSERT_OFF
    // A taken command word closes the input; the check looks at the ready right after the accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("command accepted while a line is in progress");

    // The square root never overshoots the sum of squares.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DMUL) |-> (PW'(r_root) * PW'(r_root) <= r_target))
        else $error("square root exceeds its radicand");

    // The gap counter stays at or below its reload value, gap_span, while walking.
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |-> (r_gc <= gap_span))
        else $error("gap counter beyond the gap length");
`endif

endmodule
